@@ rtl/apr_pkg.sv @@
// Shared types and constants for the aging page replacement unit.
// No dependencies; used by apr_ctrl, apr_dp and aging_page_replacement_unit.
`timescale 1ns / 1ps
`default_nettype none

package apr_pkg;

  // Fixed field widths
  localparam int TIME_W    = 32;
  localparam int IN_PAGE_W = 16;
  localparam int AGE_W     = 8;
  localparam int IDX_OUT_W = 4;
  localparam int CFG_W     = 5;
  localparam int CFG_RESET = 16;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_COMMIT
  } apr_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture the accepted transaction, set up the scan
    logic read;    // read the frame at the scan index, advance the index
    logic commit;  // write the hit/victim frame, load the result register
  } apr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;  // the scan index points at the last frame in use
    logic out_free;   // the result register can take a new result
  } apr_stat_t;

endpackage

`default_nettype wire

@@ rtl/apr_ctrl.sv @@
// Controller state machine for the aging page replacement unit.
// Depends on apr_pkg; drives apr_dp through apr_cmd_t, watches apr_stat_t.
`timescale 1ns / 1ps
`default_nettype none

module apr_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  apr_pkg::apr_stat_t stat,
  output apr_pkg::apr_cmd_t  cmd
);

  apr_pkg::apr_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= apr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      apr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = apr_pkg::ST_SCAN;
        end
      end
      apr_pkg::ST_SCAN: begin
        cmd.read = 1'b1;
        if (stat.scan_last) begin
          state_next = apr_pkg::ST_LAST;
        end
      end
      apr_pkg::ST_LAST: begin
        // last read word is processed in this cycle
        state_next = apr_pkg::ST_COMMIT;
      end
      apr_pkg::ST_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = apr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = apr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/apr_dp.sv @@
// Datapath for the aging page replacement unit: frame memory, scan pipeline,
// aging, hit search, victim selection and result register. Depends on apr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module apr_dp #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16
) (
  input  wire                               clk,
  input  wire                               rst,
  input  apr_pkg::apr_cmd_t                  cmd,
  output apr_pkg::apr_stat_t                 stat,
  input  wire                               cfg_we,
  input  wire [apr_pkg::CFG_W-1:0]          cfg_wdata,
  input  wire [apr_pkg::TIME_W-1:0]         access_time,
  input  wire [apr_pkg::IN_PAGE_W-1:0]      page_number,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic                              hit,
  output logic [apr_pkg::IDX_OUT_W-1:0]     frame_index,
  output logic [apr_pkg::IN_PAGE_W-1:0]     evicted_page
);

  localparam int PW = (PAGE_BITS < apr_pkg::IN_PAGE_W) ? PAGE_BITS : apr_pkg::IN_PAGE_W;
  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int AW = apr_pkg::AGE_W;
  localparam int WW = PW + AW + 1;  // {page, age, referenced}

  // Configuration and per-transaction registers
  logic [apr_pkg::CFG_W-1:0]  frames_in_use;
  logic [apr_pkg::TIME_W-1:0] last_time;
  logic [PW-1:0]              cur_page;
  logic                       age_flag;
  logic [IW-1:0]              last_idx;
  logic [IW-1:0]              last_idx_next;
  logic [IW-1:0]              rd_idx;

  // Frame memory and valid bits
  logic [WW-1:0] mem [FRAMES];
  logic [FRAMES-1:0] vbit;
  logic [WW-1:0] rd_q;
  logic          rd_v;
  logic [IW-1:0] rd_pj;
  logic          rd_valid;

  // Scan results
  logic          hit_found;
  logic [IW-1:0] hit_idx;
  logic [AW-1:0] hit_age;
  logic [IW-1:0] best_idx;
  logic [AW-1:0] best_age;
  logic [PW-1:0] best_page;

  // Processing stage signals
  logic [PW-1:0] d_page;
  logic [AW-1:0] d_age;
  logic          d_ref;
  logic [AW-1:0] new_age;
  logic          take_best;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [WW-1:0] mem_wdata;
  logic [IW-1:0] sel_idx;

  // Active frame count clamped to 1..FRAMES, as last index
  always_comb begin
    int lim;
    lim = int'(frames_in_use);
    if (lim < 1) lim = 1;
    if (lim > FRAMES) lim = FRAMES;
    last_idx_next = IW'(lim - 1);
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= apr_pkg::CFG_W'(apr_pkg::CFG_RESET);
    end else if (cfg_we) begin
      frames_in_use <= cfg_wdata;
    end
  end

  // Capture the access and decide on aging
  always_ff @(posedge clk) begin
    if (rst) begin
      last_time <= '0;
    end else if (cmd.load && (access_time > last_time)) begin
      last_time <= access_time;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_page <= page_number[PW-1:0];
      age_flag <= (access_time > last_time) && (last_time != '0);
      last_idx <= last_idx_next;
    end
  end

  // Scan index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_idx <= '0;
    end else if (cmd.read) begin
      rd_idx <= rd_idx + 1'b1;
    end
  end

  assign stat.scan_last = (rd_idx == last_idx);
  assign stat.out_free  = !out_valid || out_ready;

  // Registered memory read
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_q  <= mem[rd_idx];
      rd_v  <= vbit[rd_idx];
      rd_pj <= rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.read;
    end
  end

  // Decode read word; a never-written frame reads as empty
  always_comb begin
    d_page = rd_v ? rd_q[WW-1 -: PW] : '0;
    d_age  = rd_v ? rd_q[AW:1] : '0;
    d_ref  = rd_v ? rd_q[0] : 1'b0;
    new_age = d_age;
    if (age_flag && (d_page != '0)) begin
      new_age = {d_ref, d_age[AW-1:1]};
    end
    take_best = (rd_pj == '0) || (new_age < best_age) ||
                ((new_age == best_age) && (d_page < best_page));
  end

  // Hit search and victim tracking
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hit_found <= 1'b0;
    end else if (rd_valid) begin
      if (!hit_found && (d_page == cur_page)) begin
        hit_found <= 1'b1;
        hit_idx   <= rd_pj;
        hit_age   <= new_age;
      end
      if (take_best) begin
        best_idx  <= rd_pj;
        best_age  <= new_age;
        best_page <= d_page;
      end
    end
  end

  // Memory write: aging write-back during the scan, final update at commit
  assign sel_idx = hit_found ? hit_idx : best_idx;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_pj;
    mem_wdata = {d_page, new_age, 1'b0};
    if (cmd.commit) begin
      mem_we    = 1'b1;
      mem_waddr = sel_idx;
      mem_wdata = hit_found ? {cur_page, hit_age, 1'b1} : {cur_page, {AW{1'b0}}, 1'b1};
    end else if (rd_valid && age_flag) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vbit <= '0;
    end else if (mem_we) begin
      vbit[mem_waddr] <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit          <= hit_found;
      frame_index  <= apr_pkg::IDX_OUT_W'(sel_idx);
      evicted_page <= hit_found ? '0 : apr_pkg::IN_PAGE_W'(best_page);
    end
  end

`ifndef SYNTH
  // Result register is never overwritten while a result is pending
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("commit while result pending");

  // Processing stage only sees data from a read issued the cycle before
  a_rd_pipe: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> $past(cmd.read))
    else $error("read data without read");

  // Scan stays inside the frames in use
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    cmd.read |-> (rd_idx <= last_idx))
    else $error("scan index past last frame");

  // A commit always presents a result next cycle
  a_commit_out: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("commit without result");
`endif

endmodule

`default_nettype wire

@@ rtl/aging_page_replacement_unit.sv @@
// Top level of the aging page replacement unit.
// Depends on apr_pkg; instantiates apr_ctrl and apr_dp.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Input channel (in_valid/in_ready) carries one access: access_time and
//   page_number. Output channel (out_valid/out_ready) returns one result per
//   access: hit, frame_index and evicted_page.
//   cfg_we/cfg_wdata writes frames_in_use (0 acts as 1, above FRAMES acts as
//   FRAMES); write it only while the unit is idle.
// Timing:
//   After a transaction is accepted, the frames in use are scanned one per
//   cycle through the single read port of the frame memory (aging write-back,
//   hit search and victim choice in one pass). The result register is loaded
//   at commit, after the scan and a last processing state; a new access is
//   accepted only once the controller is back in idle, after that commit.
// Reset:
//   Synchronous, active high. All frames read as empty with zero age, the
//   stored tick is zero and frames_in_use is 16.
// Stall:
//   The result register holds a finished result while out_ready is low; the
//   next access is still accepted and scanned, then waits before its update
//   until the register frees up.
module aging_page_replacement_unit #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_we,
  input  wire [apr_pkg::CFG_W-1:0]          cfg_wdata,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire [apr_pkg::TIME_W-1:0]         access_time,
  input  wire [apr_pkg::IN_PAGE_W-1:0]      page_number,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic                              hit,
  output logic [apr_pkg::IDX_OUT_W-1:0]     frame_index,
  output logic [apr_pkg::IN_PAGE_W-1:0]     evicted_page
);

  apr_pkg::apr_cmd_t  cmd;
  apr_pkg::apr_stat_t stat;

  apr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  apr_dp #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .access_time  (access_time),
    .page_number  (page_number),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hit          (hit),
    .frame_index  (frame_index),
    .evicted_page (evicted_page)
  );

endmodule

`default_nettype wire

@@ tb/aging_page_replacement_unit_tb.sv @@
// Testbench for aging_page_replacement_unit: a directed access script, then random access phases.
// Every result is checked against an in-bench model of the aging frame table, or a typed script outcome.
// Depends on apr_pkg and the aging_page_replacement_unit RTL.
`timescale 1ns / 1ps

module aging_page_replacement_unit_tb;

  localparam int TW          = apr_pkg::TIME_W;
  localparam int PW          = apr_pkg::IN_PAGE_W;
  localparam int IW          = apr_pkg::IDX_OUT_W;
  localparam int CW          = apr_pkg::CFG_W;
  localparam int FRAMES      = 16;
  localparam int QUIET       = FRAMES + 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 82;
  localparam int PRINT_CAP   = 40;

  typedef struct packed {
    logic          hit;
    logic [IW-1:0] slot;
    logic [PW-1:0] evicted;
  } access_outcome_t;

  typedef enum logic {STEP_ACCESS, STEP_WRITE_FRAMES} step_kind_t;

  typedef struct {
    step_kind_t      kind;
    logic [TW-1:0]   tick;
    logic [PW-1:0]   page;
    logic [CW-1:0]   frames;
    bit              typed;
    access_outcome_t want;
  } script_step_t;

  // DUT connections
  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_we = 1'b0;
  logic [CW-1:0] cfg_wdata = '0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [TW-1:0] access_time = '0;
  logic [PW-1:0] page_number = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic          hit;
  logic [IW-1:0] frame_index;
  logic [PW-1:0] evicted_page;

  // Frame table model
  logic [PW-1:0] frame_pg [FRAMES];
  logic [7:0]    frame_age[FRAMES];
  logic          frame_ref[FRAMES];
  logic [TW-1:0] last_tick;
  logic [CW-1:0] frames_cfg;

  access_outcome_t pending_outcomes[$];
  script_step_t    access_script[$];
  logic [PW-1:0]   page_pool[$];
  logic [TW-1:0]   cur_tick;
  int              mismatches = 0;
  int              results_seen = 0;
  int              cycle_count = 0;
  bit              steady = 1'b0;

  aging_page_replacement_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .access_time  (access_time),
    .page_number  (page_number),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hit          (hit),
    .frame_index  (frame_index),
    .evicted_page (evicted_page)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Random idle draw, shared by both sides
  function automatic bit idle_draw();
    return !steady && ($urandom_range(99) < 38);
  endfunction

  // Apply one access to the frame table and return its outcome
  function automatic access_outcome_t age_and_place(logic [TW-1:0] tick, logic [PW-1:0] page);
    int              n;
    int              j;
    int              found;
    int              victim;
    access_outcome_t r;
    n = (frames_cfg == 0) ? 1 : ((frames_cfg > FRAMES) ? FRAMES : int'(frames_cfg));
    found = -1;
    victim = 0;
    // Tick advance after the first stored tick: age occupied frames in use, clear their referenced bits
    if (tick > last_tick) begin
      if (last_tick != 0) begin
        for (j = 0; j < n; j++) begin
          if (frame_pg[j] != 0) frame_age[j] = {frame_ref[j], frame_age[j][7:1]};
          frame_ref[j] = 1'b0;
        end
      end
      last_tick = tick;
    end
    for (j = 0; j < n; j++) begin
      if (found < 0 && frame_pg[j] == page) found = j;
    end
    if (found >= 0) begin
      frame_ref[found] = 1'b1;
      r.hit = 1'b1;
      r.slot = found[IW-1:0];
      r.evicted = '0;
      return r;
    end
    // Miss: least age, then smaller page, then lower index
    for (j = 1; j < n; j++) begin
      if (frame_age[j] < frame_age[victim] ||
          (frame_age[j] == frame_age[victim] && frame_pg[j] < frame_pg[victim]))
        victim = j;
    end
    r.hit = 1'b0;
    r.slot = victim[IW-1:0];
    r.evicted = frame_pg[victim];
    frame_pg[victim] = page;
    frame_age[victim] = '0;
    frame_ref[victim] = 1'b1;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (mismatches < PRINT_CAP)
      $display("mismatch: %s got %0h want %0h (result %0d, cycle %0d)",
               what, got, want, results_seen, cycle_count);
    mismatches++;
  endtask

  // Drive one access; valid stays high after acceptance unless a gap follows
  task automatic send_access(input logic [TW-1:0] tick, input logic [PW-1:0] page,
                             input bit typed, input access_outcome_t want);
    access_outcome_t predicted;
    if (idle_draw()) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (idle_draw()) @(posedge clk);
    end
    predicted = age_and_place(tick, page);
    pending_outcomes.push_back(typed ? want : predicted);
    in_valid    <= 1'b1;
    access_time <= tick;
    page_number <= page;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drain all results, let the unit go quiet, then write frames_in_use
  task automatic write_frames(input logic [CW-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (QUIET) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    frames_cfg = value;
  endtask

  task automatic add_access(input logic [TW-1:0] tick, input logic [PW-1:0] page,
                            input bit typed, input logic h, input logic [IW-1:0] s,
                            input logic [PW-1:0] ev);
    script_step_t st;
    st.kind = STEP_ACCESS;
    st.tick = tick;
    st.page = page;
    st.frames = '0;
    st.typed = typed;
    st.want.hit = h;
    st.want.slot = s;
    st.want.evicted = ev;
    access_script.push_back(st);
  endtask

  task automatic add_write(input logic [CW-1:0] value);
    script_step_t st;
    st.kind = STEP_WRITE_FRAMES;
    st.tick = '0;
    st.page = '0;
    st.frames = value;
    st.typed = 1'b0;
    st.want = '0;
    access_script.push_back(st);
  endtask

  // Next tick: mostly repeats and small steps, some jumps and some going back
  function automatic logic [TW-1:0] next_tick(logic [TW-1:0] t);
    int d;
    d = $urandom_range(99);
    if (d < 45) return t;
    if (d < 85) return t + $urandom_range(1, 3);
    if (d < 92) return t + $urandom;
    if (d < 96) return $urandom;
    return t - $urandom_range(1, 50);
  endfunction

  // One random phase: a page pool a little larger than the frames in use
  task automatic run_phase(input logic [CW-1:0] value);
    int              n;
    int              k;
    int              d;
    logic [PW-1:0]   page;
    access_outcome_t none;
    none = '0;
    write_frames(value);
    n = (value == 0) ? 1 : ((value > FRAMES) ? FRAMES : int'(value));
    page_pool.delete();
    for (k = 0; k < n + $urandom_range(1, 4); k++)
      page_pool.push_back(PW'(($urandom_range(99) < 70) ? $urandom_range(1, 65535)
                                                        : $urandom_range(1, 40)));
    for (k = 0; k < PHASE_ITEMS; k++) begin
      d = $urandom_range(99);
      if (d < 85)      page = page_pool[$urandom_range(0, page_pool.size() - 1)];
      else if (d < 95) page = PW'($urandom_range(0, 65535));
      else             page = '0;
      cur_tick = next_tick(cur_tick);
      send_access(cur_tick, page, 1'b0, none);
    end
  endtask

  // Receiver side: random backpressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !idle_draw();
    end
  end

  // Result check against the oldest pending outcome
  always @(posedge clk) begin : result_check
    access_outcome_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_outcomes.size() == 0) begin
        flag_mismatch("result with none pending, frame_index", 32'(frame_index), 32'd0);
      end else begin
        want = pending_outcomes.pop_front();
        if (hit !== want.hit) flag_mismatch("hit", 32'(hit), 32'(want.hit));
        if (frame_index !== want.slot)
          flag_mismatch("frame_index", 32'(frame_index), 32'(want.slot));
        if (evicted_page !== want.evicted)
          flag_mismatch("evicted_page", 32'(evicted_page), 32'(want.evicted));
      end
      results_seen++;
    end
  end

  // Watchdog
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results pending", cycle_count,
             pending_outcomes.size());
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : main_flow
    int i;
    for (i = 0; i < FRAMES; i++) begin
      frame_pg[i] = '0;
      frame_age[i] = '0;
      frame_ref[i] = 1'b0;
    end
    last_tick = '0;
    frames_cfg = 5'd16;
    cur_tick = 32'd8;

    // Directed script; typed outcomes where they follow directly from reset state
    add_access(32'd0, 16'h0001, 1'b1, 1'b0, 4'd0, 16'h0000);   // first fill, frame 0
    add_access(32'd0, 16'h0001, 1'b1, 1'b1, 4'd0, 16'h0000);   // hit
    add_access(32'd0, 16'hFFFF, 1'b1, 1'b0, 4'd1, 16'h0000);   // top page, empty frame 1
    add_access(32'd0, 16'h0000, 1'b1, 1'b1, 4'd2, 16'h0000);   // page zero hits empty frame
    add_access(32'd5, 16'h0001, 1'b1, 1'b1, 4'd0, 16'h0000);   // first tick only stored
    add_access(32'd3, 16'hFFFF, 1'b1, 1'b1, 4'd1, 16'h0000);   // tick goes back
    add_access(32'hFFFF_FFFF, 16'h8000, 1'b0, 1'b0, 4'd0, 16'h0000); // aging, top tick
    add_write(5'd3);
    add_access(32'hFFFF_FFFF, 16'h0000, 1'b0, 1'b0, 4'd0, 16'h0000); // page zero, no empty frame
    add_access(32'hFFFF_FFFF, 16'h0000, 1'b0, 1'b0, 4'd0, 16'h0000);
    add_write(5'd0);                                           // zero acts as one frame
    add_access(32'd7, 16'h00AA, 1'b1, 1'b0, 4'd0, 16'h0001);
    add_access(32'd7, 16'h00AA, 1'b1, 1'b1, 4'd0, 16'h0000);
    add_access(32'd7, 16'h0055, 1'b1, 1'b0, 4'd0, 16'h00AA);
    add_write(5'd31);                                          // above range acts as all frames
    add_access(32'd8, 16'h0055, 1'b0, 1'b0, 4'd0, 16'h0000);
    add_access(32'd0, 16'h1234, 1'b0, 1'b0, 4'd0, 16'h0000);
    add_access(32'd1, 16'h5A5A, 1'b0, 1'b0, 4'd0, 16'h0000);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (access_script[i]) begin
      if (access_script[i].kind == STEP_WRITE_FRAMES)
        write_frames(access_script[i].frames);
      else
        send_access(access_script[i].tick, access_script[i].page,
                    access_script[i].typed, access_script[i].want);
    end

    // Random phases across frame counts; one phase runs without idling
    run_phase(5'd16);
    run_phase(5'd5);
    run_phase(5'd1);
    run_phase(5'd0);
    run_phase(5'd31);
    steady = 1'b1;
    run_phase(5'd12);
    steady = 1'b0;
    run_phase(5'd2);
    run_phase(5'd16);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (QUIET) @(posedge clk);

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/apr_pkg.sv
rtl/apr_ctrl.sv
rtl/apr_dp.sv
rtl/aging_page_replacement_unit.sv
tb/aging_page_replacement_unit_tb.sv
